// ----- design/fsc_pkg.sv -----
`default_nettype none

package fsc_pkg;

    // Alphabet side length and fixed field widths
    localparam int SIDE_DEFAULT = 5;
    localparam int NUM_SQUARES  = 4;
    localparam int LETTER_W     = 5;
    localparam int OP_W         = 3;
    localparam int SEL_W        = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_KEY_START  = 3'd0;
    localparam logic [OP_W-1:0] OP_KEY_LETTER = 3'd1;
    localparam logic [OP_W-1:0] OP_KEY_FINISH = 3'd2;
    localparam logic [OP_W-1:0] OP_ENCRYPT    = 3'd3;
    localparam logic [OP_W-1:0] OP_DECRYPT    = 3'd4;

    // Square numbers used by the cipher operations
    localparam logic [SEL_W-1:0] SQ_ONE   = 2'd0;
    localparam logic [SEL_W-1:0] SQ_TWO   = 2'd1;
    localparam logic [SEL_W-1:0] SQ_THREE = 2'd2;
    localparam logic [SEL_W-1:0] SQ_FOUR  = 2'd3;

    // Status codes
    localparam logic STATUS_DONE      = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [SEL_W-1:0]    square_select;
        logic [LETTER_W-1:0] letter_first;
        logic [LETTER_W-1:0] letter_second;
    } item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] out_first;
        logic [LETTER_W-1:0] out_second;
        logic                status;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_LOOKUP,
        ST_DONE
    } fsc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic key_start;
        logic key_place;
        logic fill_start;
        logic fill_step;
        logic pos_read;
        logic let_read;
        logic load_out;
    } fsc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic            all_ready;
        logic            sweep_last;
        logic            out_free;
    } fsc_status_t;

endpackage

`default_nettype wire

// ----- design/four_square_cipher.sv -----
`default_nettype none

// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_stall      fsc_pkg::item_t
// result    out        result_valid / result_stall  fsc_pkg::result_t
//
// One transaction at a time. Key start, key letter, unused codes and cipher-not-ready
// load their result (raising result_valid) directly after execution, and the next item
// is taken once that load is done; a cipher pair adds position lookup, then letter lookup,
// before the load, and key finish adds the letter sweep that places one letter per cycle.
// A result waiting in the output register does not block the input; a stalled one
// holds the next finished result back. rst_n clears control, ready bits and used
// letters; square memories are not cleared and are only read once all four are finished.
module four_square_cipher #(
    parameter int SIDE = fsc_pkg::SIDE_DEFAULT
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              item_valid,
    output logic             item_stall,
    input  fsc_pkg::item_t   item,
    output logic             result_valid,
    input  wire              result_stall,
    output fsc_pkg::result_t result
);
    import fsc_pkg::*;

    fsc_cmd_t    cmd;
    fsc_status_t stat;

    fsc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    fsc_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

`default_nettype wire

// ----- design/fsc_ctrl.sv -----
`default_nettype none

module fsc_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  fsc_pkg::fsc_status_t stat,
    output fsc_pkg::fsc_cmd_t    cmd
);
    import fsc_pkg::*;

    fsc_state_t state_reg;
    fsc_state_t state_next;
    logic       is_cipher;

    assign is_cipher = (stat.operation == OP_ENCRYPT) || (stat.operation == OP_DECRYPT);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (stat.operation)
                    OP_KEY_FINISH: state_next = ST_FILL;
                    OP_ENCRYPT,
                    OP_DECRYPT:    state_next = stat.all_ready ? ST_LOOKUP : ST_DONE;
                    default:       state_next = ST_DONE;
                endcase
            end
            ST_FILL:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.take   = item_valid;
            end
            ST_EXEC:
            begin
                cmd.key_start  = (stat.operation == OP_KEY_START);
                cmd.key_place  = (stat.operation == OP_KEY_LETTER);
                cmd.fill_start = (stat.operation == OP_KEY_FINISH);
                cmd.pos_read   = is_cipher && stat.all_ready;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
            end
            ST_LOOKUP:
            begin
                cmd.let_read = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/fsc_dp.sv -----
`default_nettype none

module fsc_dp #(
    parameter int SIDE = fsc_pkg::SIDE_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  fsc_pkg::item_t       item,
    output logic                 result_valid,
    input  wire                  result_stall,
    output fsc_pkg::result_t     result,
    input  fsc_pkg::fsc_cmd_t    cmd,
    output fsc_pkg::fsc_status_t stat
);
    import fsc_pkg::*;

    localparam int ALPHA = SIDE * SIDE;
    localparam int LW    = $clog2(ALPHA);
    localparam int RW    = $clog2(SIDE);
    localparam int PW    = 2 * RW;
    localparam int DEPTH = NUM_SQUARES * ALPHA;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(ALPHA + 1);

    // Square contents and letter positions (row, column)
    logic [LW-1:0] let_mem [DEPTH];
    logic [PW-1:0] pos_mem [DEPTH];

    item_t            cmd_reg;
    logic [ALPHA-1:0] used_reg;
    logic [CW-1:0]    fill_cnt_reg;
    logic [RW-1:0]    fill_row_reg;
    logic [RW-1:0]    fill_col_reg;
    logic [SEL_W-1:0] active_reg;
    logic [NUM_SQUARES-1:0] ready_reg;
    logic [LW-1:0]    sweep_reg;
    logic [PW-1:0]    pa_reg;
    logic [PW-1:0]    pb_reg;
    logic [LW-1:0]    la_reg;
    logic [LW-1:0]    lb_reg;
    logic             result_valid_reg;
    result_t          result_reg;

    logic             all_ready;
    logic             is_cipher;
    logic             out_free;
    logic             sweep_last;
    logic [LW-1:0]    key_letter;
    logic [LW-1:0]    place_letter;
    logic             place_used;
    logic             place_en;
    logic [AW-1:0]    cell_addr;
    logic [AW-1:0]    slot_addr;
    logic [LW-1:0]    a_ext;
    logic [LW-1:0]    b_ext;
    logic [LW-1:0]    a_letter;
    logic [LW-1:0]    b_letter;
    logic             encrypt;
    logic [SEL_W-1:0] sq_find_a;
    logic [SEL_W-1:0] sq_find_b;
    logic [SEL_W-1:0] sq_out_a;
    logic [SEL_W-1:0] sq_out_b;
    logic [AW-1:0]    pa_addr;
    logic [AW-1:0]    pb_addr;
    logic [AW-1:0]    la_addr;
    logic [AW-1:0]    lb_addr;
    logic [RW-1:0]    r1;
    logic [RW-1:0]    c1;
    logic [RW-1:0]    r2;
    logic [RW-1:0]    c2;

    assign all_ready  = &ready_reg;
    assign is_cipher  = (cmd_reg.operation == OP_ENCRYPT) || (cmd_reg.operation == OP_DECRYPT);
    assign out_free   = !result_valid_reg || !result_stall;
    assign sweep_last = (sweep_reg == LW'(ALPHA - 1));

    assign stat.operation  = cmd_reg.operation;
    assign stat.all_ready  = all_ready;
    assign stat.sweep_last = sweep_last;
    assign stat.out_free   = out_free;

    // Hold the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cmd_reg <= item;
        end
    end

    // Pick the letter to place: key letter or sweep letter
    assign key_letter   = LW'(cmd_reg.letter_first);
    assign place_letter = cmd.key_place ? key_letter : sweep_reg;
    assign place_used   = (place_letter < LW'(ALPHA)) ? used_reg[place_letter] : 1'b1;
    assign place_en     = (cmd.key_place || cmd.fill_step)
                          && (fill_cnt_reg < CW'(ALPHA))
                          && (place_letter < LW'(ALPHA))
                          && !place_used;
    assign cell_addr    = AW'(active_reg) * AW'(ALPHA) + AW'(fill_cnt_reg);
    assign slot_addr    = AW'(active_reg) * AW'(ALPHA) + AW'(place_letter);

    // Keying state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            fill_cnt_reg <= '0;
            fill_row_reg <= '0;
            fill_col_reg <= '0;
            active_reg   <= '0;
            ready_reg    <= '0;
            sweep_reg    <= '0;
        end
        else
        begin
            if (cmd.key_start)
            begin
                active_reg                        <= cmd_reg.square_select;
                used_reg                          <= '0;
                fill_cnt_reg                      <= '0;
                fill_row_reg                      <= '0;
                fill_col_reg                      <= '0;
                ready_reg[cmd_reg.square_select]  <= 1'b0;
            end
            if (place_en)
            begin
                used_reg[place_letter] <= 1'b1;
                fill_cnt_reg           <= fill_cnt_reg + CW'(1);
                if (fill_col_reg == RW'(SIDE - 1))
                begin
                    fill_col_reg <= '0;
                    fill_row_reg <= fill_row_reg + RW'(1);
                end
                else
                begin
                    fill_col_reg <= fill_col_reg + RW'(1);
                end
            end
            // Sweep all letters on key finish
            if (cmd.fill_start)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.fill_step)
            begin
                sweep_reg <= sweep_reg + LW'(1);
                if (sweep_last)
                begin
                    ready_reg[active_reg] <= 1'b1;
                end
            end
        end
    end

    // Clamp cipher letters and pick squares
    assign a_ext     = LW'(cmd_reg.letter_first);
    assign b_ext     = LW'(cmd_reg.letter_second);
    assign a_letter  = (a_ext >= LW'(ALPHA)) ? LW'(ALPHA - 1) : a_ext;
    assign b_letter  = (b_ext >= LW'(ALPHA)) ? LW'(ALPHA - 1) : b_ext;
    assign encrypt   = (cmd_reg.operation == OP_ENCRYPT);
    assign sq_find_a = encrypt ? SQ_TWO   : SQ_ONE;
    assign sq_find_b = encrypt ? SQ_FOUR  : SQ_THREE;
    assign sq_out_a  = encrypt ? SQ_ONE   : SQ_TWO;
    assign sq_out_b  = encrypt ? SQ_THREE : SQ_FOUR;
    assign pa_addr   = AW'(sq_find_a) * AW'(ALPHA) + AW'(a_letter);
    assign pb_addr   = AW'(sq_find_b) * AW'(ALPHA) + AW'(b_letter);

    // Swap columns between the two located cells
    assign r1      = pa_reg[PW-1:RW];
    assign c1      = pa_reg[RW-1:0];
    assign r2      = pb_reg[PW-1:RW];
    assign c2      = pb_reg[RW-1:0];
    assign la_addr = AW'(sq_out_a) * AW'(ALPHA) + AW'(r1) * AW'(SIDE) + AW'(c2);
    assign lb_addr = AW'(sq_out_b) * AW'(ALPHA) + AW'(r2) * AW'(SIDE) + AW'(c1);

    // Memories: one write port, two registered read ports each
    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            let_mem[cell_addr] <= place_letter;
            pos_mem[slot_addr] <= {fill_row_reg, fill_col_reg};
        end
        if (cmd.pos_read)
        begin
            pa_reg <= pos_mem[pa_addr];
            pb_reg <= pos_mem[pb_addr];
        end
        if (cmd.let_read)
        begin
            la_reg <= let_mem[la_addr];
            lb_reg <= let_mem[lb_addr];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (is_cipher && all_ready)
            begin
                result_reg.out_first  <= la_reg[LETTER_W-1:0];
                result_reg.out_second <= lb_reg[LETTER_W-1:0];
            end
            else
            begin
                result_reg.out_first  <= '0;
                result_reg.out_second <= '0;
            end
            result_reg.status <= (is_cipher && !all_ready) ? STATUS_NOT_READY : STATUS_DONE;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
